>>> sv/ensc_pkg.sv
// Package for the environmental sensor compensation pipeline.
// Holds shared types, pipeline depths, formula constants and arithmetic helpers.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ensc_pkg;

    localparam int FrDepth  = 14;
    localparam int DivSteps = 64;
    localparam int BkDepth  = 8;
    localparam int FifoDepth = 2;

    localparam logic [32:0] TFineOff   = 33'd128000;
    localparam logic [20:0] PresBase   = 21'd1048576;
    localparam logic [31:0] PresScale  = 32'd3125;
    localparam logic [31:0] HumOff     = 32'd76800;
    localparam logic [31:0] HumMax     = 32'd419430400;
    localparam logic [31:0] HumBias    = 32'd2097152;
    localparam logic [31:0] HumRound   = 32'd16384;
    localparam logic [31:0] HumHalf    = 32'd32768;
    localparam logic [31:0] HumRound2  = 32'd8192;
    localparam logic [63:0] PresBias   = 64'h0000_8000_0000_0000;

    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t CfgCalTemperature = 3'd0;
    localparam cfg_idx_t CfgCalPressureA   = 3'd1;
    localparam cfg_idx_t CfgCalPressureB   = 3'd2;
    localparam cfg_idx_t CfgCalPressureC   = 3'd3;
    localparam cfg_idx_t CfgCalHumidityA   = 3'd4;
    localparam cfg_idx_t CfgCalHumidityB   = 3'd5;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
        logic [7:0]  h1;
        logic [15:0] h2;
        logic [7:0]  h3;
        logic [11:0] h4;
        logic [11:0] h5;
        logic [7:0]  h6;
    } cal_t;

    typedef struct packed {
        logic        valid;
        logic [19:0] adc_p;
        logic [15:0] adc_h;
        logic [31:0] tx1;
        logic [31:0] td;
        logic [31:0] ma;
        logic [31:0] dd;
        logic [31:0] ta;
        logic [31:0] te;
        logic [31:0] tfine;
        logic [31:0] temp;
        logic [31:0] hv;
        logic [32:0] v1;
        logic [63:0] sq;
        logic [48:0] v5;
        logic [48:0] v2f;
        logic [48:0] pl6;
        logic [31:0] ph6;
        logic [48:0] pl3;
        logic [31:0] ph3;
        logic [63:0] m6;
        logic [63:0] m3;
        logic [63:0] v2;
        logic [63:0] v1b;
        logic [47:0] wl;
        logic [31:0] wh;
        logic [63:0] x;
        logic [63:0] v1c;
        logic [43:0] xl;
        logic [31:0] xh;
        logic [63:0] num;
        logic        ok;
        logic [63:0] dvd;
        logic [63:0] dvs;
        logic        neg;
        logic [31:0] h5hv;
        logic [31:0] hvh6;
        logic [31:0] hvh3;
        logic [31:0] hx;
        logic [31:0] ya;
        logic [31:0] yb;
        logic [31:0] y1;
        logic [31:0] y2;
        logic [31:0] hy;
        logic [31:0] hm;
        logic [31:0] hs2;
        logic [31:0] ht;
        logic [16:0] hum;
    } fr_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] rem;
        logic [63:0] dq;
        logic [63:0] dvs;
        logic        neg;
        logic        ok;
        logic [31:0] temp;
        logic [16:0] hum;
    } dv_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] p;
        logic [63:0] q;
        logic [48:0] q9l;
        logic [31:0] q9h;
        logic [48:0] p8l;
        logic [31:0] p8h;
        logic [63:0] r;
        logic [63:0] e2;
        logic [63:0] rl;
        logic [31:0] rm;
        logic [63:0] e1;
        logic [63:0] s;
        logic [63:0] pf;
        logic [31:0] pres;
        logic        ok;
        logic [31:0] temp;
        logic [16:0] hum;
    } bk_t;

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] pres;
        logic [16:0] hum;
        logic        ok;
    } res_t;

    function automatic logic [31:0] sra32(logic [31:0] v, int sh);
        return 32'($signed(v) >>> sh);
    endfunction

    function automatic logic [63:0] sra64(logic [63:0] v, int sh);
        return 64'($signed(v) >>> sh);
    endfunction

    function automatic logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
        return 32'(a * b);
    endfunction

    function automatic logic [31:0] sx16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sx12(logic [11:0] v);
        return {{20{v[11]}}, v};
    endfunction

    function automatic logic [31:0] sx8(logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

    function automatic logic [63:0] sx49(logic [48:0] v);
        return {{15{v[48]}}, v};
    endfunction

    function automatic logic [63:0] sx16w(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

endpackage

`default_nettype wire

>>> sv/ensc_front.sv
// Front pipeline: temperature, pressure dividend and divisor, and humidity.
// Fourteen register stages; uses ensc_pkg.
`default_nettype none

module ensc_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  wire logic [19:0]   raw_pressure,
    input  wire logic [19:0]   raw_temperature,
    input  wire logic [15:0]   raw_humidity,
    input  wire ensc_pkg::cal_t cal_i,
    output ensc_pkg::dv_t      dout
);

    ensc_pkg::fr_t st_reg  [ensc_pkg::FrDepth];
    ensc_pkg::fr_t st_next [ensc_pkg::FrDepth];

    always_comb begin
        logic [63:0] w;
        logic [20:0] pp;
        logic [31:0] hvf;
        for (int k = 1; k < ensc_pkg::FrDepth; k++) begin
            st_next[k] = st_reg[k-1];
        end
        st_next[0] = '0;
        st_next[0].valid = in_valid;
        st_next[0].adc_p = raw_pressure;
        st_next[0].adc_h = raw_humidity;
        st_next[0].tx1 = 32'(raw_temperature >> 3) - (32'(cal_i.t1) << 1);
        st_next[0].td  = 32'(raw_temperature >> 4) - 32'(cal_i.t1);

        st_next[1].ma = ensc_pkg::mul32(st_reg[0].tx1, ensc_pkg::sx16(cal_i.t2));
        st_next[1].dd = ensc_pkg::mul32(st_reg[0].td, st_reg[0].td);

        st_next[2].ta = ensc_pkg::sra32(st_reg[1].ma, 11);
        st_next[2].te = ensc_pkg::mul32(ensc_pkg::sra32(st_reg[1].dd, 12),
                                        ensc_pkg::sx16(cal_i.t3));

        st_next[3].tfine = st_reg[2].ta + ensc_pkg::sra32(st_reg[2].te, 14);

        st_next[4].temp = ensc_pkg::sra32((st_reg[3].tfine << 2) + st_reg[3].tfine
                                          + 32'd128, 8);
        st_next[4].v1 = {st_reg[3].tfine[31], st_reg[3].tfine} - ensc_pkg::TFineOff;
        st_next[4].hv = st_reg[3].tfine - ensc_pkg::HumOff;

        st_next[5].sq   = 64'($signed(st_reg[4].v1) * $signed(st_reg[4].v1));
        st_next[5].v5   = $signed(st_reg[4].v1) * $signed(cal_i.p5);
        st_next[5].v2f  = $signed(st_reg[4].v1) * $signed(cal_i.p2);
        st_next[5].h5hv = ensc_pkg::mul32(ensc_pkg::sx12(cal_i.h5), st_reg[4].hv);
        st_next[5].hvh6 = ensc_pkg::mul32(st_reg[4].hv, ensc_pkg::sx8(cal_i.h6));
        st_next[5].hvh3 = ensc_pkg::mul32(st_reg[4].hv, 32'(cal_i.h3));

        st_next[6].pl6 = $signed({1'b0, st_reg[5].sq[31:0]}) * $signed(cal_i.p6);
        st_next[6].ph6 = ensc_pkg::mul32(st_reg[5].sq[63:32], ensc_pkg::sx16(cal_i.p6));
        st_next[6].pl3 = $signed({1'b0, st_reg[5].sq[31:0]}) * $signed(cal_i.p3);
        st_next[6].ph3 = ensc_pkg::mul32(st_reg[5].sq[63:32], ensc_pkg::sx16(cal_i.p3));
        st_next[6].hx = ensc_pkg::sra32((32'(st_reg[5].adc_h) << 14)
                                        - (ensc_pkg::sx12(cal_i.h4) << 20)
                                        - st_reg[5].h5hv + ensc_pkg::HumRound, 15);
        st_next[6].ya = ensc_pkg::sra32(st_reg[5].hvh6, 10);
        st_next[6].yb = ensc_pkg::sra32(st_reg[5].hvh3, 11) + ensc_pkg::HumHalf;

        st_next[7].m6 = ensc_pkg::sx49(st_reg[6].pl6) + {st_reg[6].ph6, 32'd0};
        st_next[7].m3 = ensc_pkg::sx49(st_reg[6].pl3) + {st_reg[6].ph3, 32'd0};
        st_next[7].y1 = ensc_pkg::mul32(st_reg[6].ya, st_reg[6].yb);

        st_next[8].v2 = st_reg[7].m6 + (ensc_pkg::sx49(st_reg[7].v5) << 17)
                        + (ensc_pkg::sx16w(cal_i.p4) << 35);
        st_next[8].v1b = ensc_pkg::sra64(st_reg[7].m3, 8)
                         + (ensc_pkg::sx49(st_reg[7].v2f) << 12);
        st_next[8].y2 = ensc_pkg::mul32(ensc_pkg::sra32(st_reg[7].y1, 10)
                                        + ensc_pkg::HumBias, ensc_pkg::sx16(cal_i.h2));

        w  = ensc_pkg::PresBias + st_reg[8].v1b;
        pp = ensc_pkg::PresBase - {1'b0, st_reg[8].adc_p};
        st_next[9].wl = w[31:0] * cal_i.p1;
        st_next[9].wh = ensc_pkg::mul32(w[63:32], 32'(cal_i.p1));
        st_next[9].x  = ({43'd0, pp} << 31) - st_reg[8].v2;
        st_next[9].hy = ensc_pkg::sra32(st_reg[8].y2 + ensc_pkg::HumRound2, 14);

        st_next[10].v1c = ensc_pkg::sra64(64'(st_reg[9].wl) + {st_reg[9].wh, 32'd0}, 33);
        st_next[10].xl  = st_reg[9].x[31:0] * ensc_pkg::PresScale[11:0];
        st_next[10].xh  = ensc_pkg::mul32(st_reg[9].x[63:32], ensc_pkg::PresScale);
        st_next[10].hm  = ensc_pkg::mul32(st_reg[9].hx, st_reg[9].hy);

        st_next[11].num = 64'(st_reg[10].xl) + {st_reg[10].xh, 32'd0};
        st_next[11].ok  = (st_reg[10].v1c != 64'd0);
        st_next[11].hs2 = ensc_pkg::mul32(ensc_pkg::sra32(st_reg[10].hm, 15),
                                          ensc_pkg::sra32(st_reg[10].hm, 15));

        st_next[12].dvd = st_reg[11].num[63] ? (64'd0 - st_reg[11].num) : st_reg[11].num;
        st_next[12].dvs = st_reg[11].v1c[63] ? (64'd0 - st_reg[11].v1c) : st_reg[11].v1c;
        st_next[12].neg = st_reg[11].num[63] ^ st_reg[11].v1c[63];
        st_next[12].ht  = ensc_pkg::mul32(ensc_pkg::sra32(st_reg[11].hs2, 7),
                                          32'(cal_i.h1));

        hvf = st_reg[12].hm - ensc_pkg::sra32(st_reg[12].ht, 4);
        if (hvf[31]) begin
            st_next[13].hum = 17'd0;
        end else if (hvf > ensc_pkg::HumMax) begin
            st_next[13].hum = 17'(ensc_pkg::HumMax >> 12);
        end else begin
            st_next[13].hum = 17'(hvf >> 12);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg <= st_next;
        end
        if (!aresetn) begin
            for (int k = 0; k < ensc_pkg::FrDepth; k++) begin
                st_reg[k].valid <= 1'b0;
            end
        end
    end

    always_comb begin
        dout       = '0;
        dout.valid = st_reg[ensc_pkg::FrDepth-1].valid;
        dout.rem   = 64'd0;
        dout.dq    = st_reg[ensc_pkg::FrDepth-1].dvd;
        dout.dvs   = st_reg[ensc_pkg::FrDepth-1].dvs;
        dout.neg   = st_reg[ensc_pkg::FrDepth-1].neg;
        dout.ok    = st_reg[ensc_pkg::FrDepth-1].ok;
        dout.temp  = st_reg[ensc_pkg::FrDepth-1].temp;
        dout.hum   = st_reg[ensc_pkg::FrDepth-1].hum;
    end

endmodule

`default_nettype wire

>>> sv/ensc_div.sv
// Pipelined radix-2 restoring divider on 64-bit magnitudes, one quotient bit per stage.
// Carries the result payload alongside; uses ensc_pkg.
`default_nettype none

module ensc_div (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          adv,
    input  wire ensc_pkg::dv_t din,
    output ensc_pkg::dv_t      dout
);

    ensc_pkg::dv_t st_reg  [ensc_pkg::DivSteps];
    ensc_pkg::dv_t st_next [ensc_pkg::DivSteps];
    ensc_pkg::dv_t prev    [ensc_pkg::DivSteps];

    always_comb begin
        logic [64:0] t;
        logic        ge;
        prev[0] = din;
        for (int k = 1; k < ensc_pkg::DivSteps; k++) begin
            prev[k] = st_reg[k-1];
        end
        for (int k = 0; k < ensc_pkg::DivSteps; k++) begin
            t  = {prev[k].rem, prev[k].dq[63]};
            ge = (t >= {1'b0, prev[k].dvs});
            st_next[k]     = prev[k];
            st_next[k].rem = ge ? 64'(t - {1'b0, prev[k].dvs}) : t[63:0];
            st_next[k].dq  = {prev[k].dq[62:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg <= st_next;
        end
        if (!aresetn) begin
            for (int k = 0; k < ensc_pkg::DivSteps; k++) begin
                st_reg[k].valid <= 1'b0;
            end
        end
    end

    assign dout = st_reg[ensc_pkg::DivSteps-1];

endmodule

`default_nettype wire

>>> sv/ensc_back.sv
// Back pipeline: quotient sign, pressure correction terms, pascal saturation.
// Eight register stages; uses ensc_pkg.
`default_nettype none

module ensc_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          adv,
    input  wire ensc_pkg::dv_t din,
    input  wire ensc_pkg::cal_t cal_i,
    output logic               out_valid,
    output ensc_pkg::res_t     out_res
);

    ensc_pkg::bk_t st_reg  [ensc_pkg::BkDepth];
    ensc_pkg::bk_t st_next [ensc_pkg::BkDepth];

    always_comb begin
        logic [63:0] qv;
        logic [63:0] pa;
        logic [31:0] sat;
        for (int k = 1; k < ensc_pkg::BkDepth; k++) begin
            st_next[k] = st_reg[k-1];
        end
        st_next[0]       = '0;
        st_next[0].valid = din.valid;
        st_next[0].p     = din.neg ? (64'd0 - din.dq) : din.dq;
        st_next[0].ok    = din.ok;
        st_next[0].temp  = din.temp;
        st_next[0].hum   = din.hum;

        qv = ensc_pkg::sra64(st_reg[0].p, 13);
        st_next[1].q   = qv;
        st_next[1].q9l = $signed({1'b0, qv[31:0]}) * $signed(cal_i.p9);
        st_next[1].q9h = ensc_pkg::mul32(qv[63:32], ensc_pkg::sx16(cal_i.p9));
        st_next[1].p8l = $signed({1'b0, st_reg[0].p[31:0]}) * $signed(cal_i.p8);
        st_next[1].p8h = ensc_pkg::mul32(st_reg[0].p[63:32], ensc_pkg::sx16(cal_i.p8));

        st_next[2].r  = ensc_pkg::sx49(st_reg[1].q9l) + {st_reg[1].q9h, 32'd0};
        st_next[2].e2 = ensc_pkg::sra64(ensc_pkg::sx49(st_reg[1].p8l)
                                        + {st_reg[1].p8h, 32'd0}, 19);

        st_next[3].rl = 64'(st_reg[2].r[31:0]) * 64'(st_reg[2].q[31:0]);
        st_next[3].rm = ensc_pkg::mul32(st_reg[2].r[31:0], st_reg[2].q[63:32])
                        + ensc_pkg::mul32(st_reg[2].r[63:32], st_reg[2].q[31:0]);

        st_next[4].e1 = ensc_pkg::sra64(st_reg[3].rl + {st_reg[3].rm, 32'd0}, 25);

        st_next[5].s = st_reg[4].p + st_reg[4].e1 + st_reg[4].e2;

        st_next[6].pf = ensc_pkg::sra64(st_reg[5].s, 8)
                        + (ensc_pkg::sx16w(cal_i.p7) << 4);

        pa = ensc_pkg::sra64(st_reg[6].pf, 8);
        if ((&pa[63:31]) || !(|pa[63:31])) begin
            sat = pa[31:0];
        end else if (pa[63]) begin
            sat = 32'h8000_0000;
        end else begin
            sat = 32'h7FFF_FFFF;
        end
        st_next[7].pres = st_reg[6].ok ? sat : 32'd0;
        st_next[7].hum  = st_reg[6].ok ? st_reg[6].hum : 17'd0;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg <= st_next;
        end
        if (!aresetn) begin
            for (int k = 0; k < ensc_pkg::BkDepth; k++) begin
                st_reg[k].valid <= 1'b0;
            end
        end
    end

    assign out_valid    = st_reg[ensc_pkg::BkDepth-1].valid;
    assign out_res.temp = st_reg[ensc_pkg::BkDepth-1].temp;
    assign out_res.pres = st_reg[ensc_pkg::BkDepth-1].pres;
    assign out_res.hum  = st_reg[ensc_pkg::BkDepth-1].hum;
    assign out_res.ok   = st_reg[ensc_pkg::BkDepth-1].ok;

endmodule

`default_nettype wire

>>> sv/env_sensor_compensation_unit.sv
// Top level of the environmental sensor compensation block.
// Holds the calibration registers and the two-entry output buffer; instantiates
// ensc_front, ensc_div and ensc_back, and uses ensc_pkg.
`default_nettype none

// The block accepts one raw pressure, temperature and humidity triple per clock while
// s_ready is high, and returns one compensated result per triple, in order. Its core
// is the 64-stage radix-2 divider for the pressure quotient, between a 14-stage front
// and an 8-stage back end. A two-entry output buffer keeps the pipeline moving while
// a result waits; the whole pipeline holds when both entries are full. Calibration
// writes take effect at once and must only be made while no triple is in flight.
module env_sensor_compensation_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [19:0]        s_raw_pressure,
    input  wire logic [19:0]        s_raw_temperature,
    input  wire logic [15:0]        s_raw_humidity,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_temperature_centi,
    output logic signed [31:0]      m_pressure_pa,
    output logic [16:0]             m_humidity_q10,
    output logic                    m_result_valid,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [47:0]        cfg_data
);

    logic [47:0] cal_temp_reg;
    logic [47:0] cal_pa_reg;
    logic [47:0] cal_pb_reg;
    logic [47:0] cal_pc_reg;
    logic [31:0] cal_ha_reg;
    logic [31:0] cal_hb_reg;

    ensc_pkg::cal_t cal;
    ensc_pkg::dv_t  front_out;
    ensc_pkg::dv_t  div_out;
    ensc_pkg::res_t back_res;
    logic           back_valid;

    ensc_pkg::res_t head_reg;
    ensc_pkg::res_t tail_reg;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    logic           adv;
    logic           push;
    logic           pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_temp_reg <= '0;
            cal_pa_reg   <= '0;
            cal_pb_reg   <= '0;
            cal_pc_reg   <= '0;
            cal_ha_reg   <= '0;
            cal_hb_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ensc_pkg::CfgCalTemperature: cal_temp_reg <= cfg_data;
                ensc_pkg::CfgCalPressureA:   cal_pa_reg   <= cfg_data;
                ensc_pkg::CfgCalPressureB:   cal_pb_reg   <= cfg_data;
                ensc_pkg::CfgCalPressureC:   cal_pc_reg   <= cfg_data;
                ensc_pkg::CfgCalHumidityA:   cal_ha_reg   <= cfg_data[31:0];
                ensc_pkg::CfgCalHumidityB:   cal_hb_reg   <= cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    assign cal.t1 = cal_temp_reg[15:0];
    assign cal.t2 = cal_temp_reg[31:16];
    assign cal.t3 = cal_temp_reg[47:32];
    assign cal.p1 = cal_pa_reg[15:0];
    assign cal.p2 = cal_pa_reg[31:16];
    assign cal.p3 = cal_pa_reg[47:32];
    assign cal.p4 = cal_pb_reg[15:0];
    assign cal.p5 = cal_pb_reg[31:16];
    assign cal.p6 = cal_pb_reg[47:32];
    assign cal.p7 = cal_pc_reg[15:0];
    assign cal.p8 = cal_pc_reg[31:16];
    assign cal.p9 = cal_pc_reg[47:32];
    assign cal.h1 = cal_ha_reg[7:0];
    assign cal.h2 = cal_ha_reg[23:8];
    assign cal.h3 = cal_ha_reg[31:24];
    assign cal.h4 = cal_hb_reg[11:0];
    assign cal.h5 = cal_hb_reg[23:12];
    assign cal.h6 = cal_hb_reg[31:24];

    assign adv     = (cnt_reg != 2'(ensc_pkg::FifoDepth));
    assign s_ready = adv;

    ensc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .adv             (adv),
        .in_valid        (s_valid),
        .raw_pressure    (s_raw_pressure),
        .raw_temperature (s_raw_temperature),
        .raw_humidity    (s_raw_humidity),
        .cal_i           (cal),
        .dout            (front_out)
    );

    ensc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .din     (front_out),
        .dout    (div_out)
    );

    ensc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .din       (div_out),
        .cal_i     (cal),
        .out_valid (back_valid),
        .out_res   (back_res)
    );

    assign push = back_valid && adv;
    assign pop  = m_valid && m_ready;
    assign cnt_next = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop))) begin
            head_reg <= back_res;
        end else if (pop && (cnt_reg == 2'd2)) begin
            head_reg <= tail_reg;
        end
        if (push && (cnt_reg == 2'd1) && !pop) begin
            tail_reg <= back_res;
        end
    end

    assign m_valid             = (cnt_reg != 2'd0);
    assign m_temperature_centi = $signed(head_reg.temp);
    assign m_pressure_pa       = $signed(head_reg.pres);
    assign m_humidity_q10      = head_reg.hum;
    assign m_result_valid      = head_reg.ok;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("Output buffer count out of range.");

    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) && !pop |=> (cnt_reg == 2'd2) && $stable(head_reg))
        else $error("Full output buffer changed without a transfer.");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_result_valid |-> (m_pressure_pa == 32'sd0) && (m_humidity_q10 == 17'd0))
        else $error("Invalid result carries nonzero pressure or humidity.");

    a_hum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_humidity_q10 <= 17'd102400))
        else $error("Humidity result above full scale.");
`endif

endmodule

`default_nettype wire
